@@ hw/rtl/spq_pkg.sv @@
// Shared types, codes and helpers for the stable priority queue.
package spq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;
    localparam int unsigned DEF_ID_WIDTH    = 16;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned PID_W    = 16;
    localparam int unsigned PRIO_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TAG_W    = 4;
    localparam int unsigned OCC_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [PRIO_W-1:0] MAX_PRIORITY = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [PID_W-1:0]    process_id;
        logic [PRIO_W-1:0]   priority_req;
    } spq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    popped_id;
        logic [PRIO_W-1:0]   popped_priority;
        logic [TAG_W-1:0]    popped_tag;
        logic [OCC_W-1:0]    occupancy;
    } spq_rsp_t;

    // Priority and tag of one stored entry.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } spq_meta_t;

    // Controls broadcast to every cell of the chain.
    typedef struct packed {
        logic              insert;
        logic              pop;
        logic [PRIO_W-1:0] prio;
    } spq_ctrl_t;

    function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
        return (p > MAX_PRIORITY) ? MAX_PRIORITY : p;
    endfunction

endpackage

@@ hw/rtl/spq_ifaces.sv @@
// Valid/ready channel interfaces for the request and response streams.
interface spq_req_if import spq_pkg::*;;
    logic     valid;
    logic     ready;
    spq_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*;;
    logic     valid;
    logic     ready;
    spq_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/spq_cell.sv @@
// One slot of the sorted shift chain: holds an entry and takes from its neighbors.
module spq_cell import spq_pkg::*;
#(
    parameter int unsigned ID_WIDTH = DEF_ID_WIDTH
)
(
    input  logic                clk,
    input  spq_ctrl_t           ctrl,
    input  logic                occupied,
    input  logic                left_stays,
    input  logic [ID_WIDTH-1:0] left_id,
    input  spq_meta_t           left_meta,
    input  logic [ID_WIDTH-1:0] right_id,
    input  spq_meta_t           right_meta,
    input  logic [ID_WIDTH-1:0] new_id,
    input  spq_meta_t           new_meta,
    output logic                stays,
    output logic [ID_WIDTH-1:0] id,
    output spq_meta_t           meta
);

    logic [ID_WIDTH-1:0] id_reg;
    logic [ID_WIDTH-1:0] id_next;
    spq_meta_t           meta_reg;
    spq_meta_t           meta_next;

    // The held entry keeps its place when it ranks equal or above the new one.
    assign stays = occupied && (meta_reg.prio >= ctrl.prio);

    always_comb
    begin
        id_next   = id_reg;
        meta_next = meta_reg;
        if (ctrl.insert && !stays)
        begin
            if (left_stays)
            begin
                id_next   = new_id;
                meta_next = new_meta;
            end
            else
            begin
                id_next   = left_id;
                meta_next = left_meta;
            end
        end
        else if (ctrl.pop)
        begin
            id_next   = right_id;
            meta_next = right_meta;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        meta_reg <= meta_next;
    end

    assign id   = id_reg;
    assign meta = meta_reg;

endmodule

@@ hw/rtl/stable_priority_queue.sv @@
// Top level of the stable priority queue built from a chain of entry cells.
//
// The req channel carries one operation per transfer: insert an entry, pop the
// front entry, or query the occupancy. Each request produces exactly one
// transfer on the rsp channel with a status, the popped entry fields and the
// occupancy after the operation.
// Entries are kept sorted in a row of cells, highest priority at the front and
// oldest first among equal priorities. All cells compare against the incoming
// priority at once and shift by one place together.
// The response becomes valid in the cycle after a request transfer.
// Throughput is one request per cycle: a new request is taken whenever the
// response register is empty or is being emptied in the same cycle.
// When the receiver stalls, the response holds and req.ready drops until the
// response is taken; no state changes meanwhile.
// Reset empties the queue at once and clears the response valid; the cell
// contents are not cleared and are never read before being written.
module stable_priority_queue import spq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int unsigned ID_WIDTH    = DEF_ID_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    spq_rsp_t         rsp_data_reg;
    spq_rsp_t         rsp_data_next;

    logic                req_fire;
    logic                is_empty;
    logic                is_full;
    spq_ctrl_t           ctrl;
    logic [ID_WIDTH-1:0] new_id;
    spq_meta_t           new_meta;

    logic [ID_WIDTH-1:0] cell_id   [QUEUE_DEPTH];
    spq_meta_t           cell_meta [QUEUE_DEPTH];
    logic                cell_stay [QUEUE_DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(QUEUE_DEPTH));

    assign ctrl.insert = req_fire && (req.data.action == ACT_INSERT) && !is_full;
    assign ctrl.pop    = req_fire && (req.data.action == ACT_POP) && !is_empty;
    assign ctrl.prio   = sat_prio(req.data.priority_req);

    assign new_id        = ID_WIDTH'(req.data.process_id);
    assign new_meta.prio = ctrl.prio;
    assign new_meta.tag  = TAG_W'(count_reg);

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                occupied;
        logic                left_stays;
        logic [ID_WIDTH-1:0] left_id;
        spq_meta_t           left_meta;
        logic [ID_WIDTH-1:0] right_id;
        spq_meta_t           right_meta;

        assign occupied = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left_stays = 1'b1;
            assign left_id    = new_id;
            assign left_meta  = new_meta;
        end
        else
        begin : g_mid
            assign left_stays = cell_stay[i-1];
            assign left_id    = cell_id[i-1];
            assign left_meta  = cell_meta[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_id   = cell_id[i];
            assign right_meta = cell_meta[i];
        end
        else
        begin : g_inner
            assign right_id   = cell_id[i+1];
            assign right_meta = cell_meta[i+1];
        end

        spq_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .left_stays (left_stays),
            .left_id    (left_id),
            .left_meta  (left_meta),
            .right_id   (right_id),
            .right_meta (right_meta),
            .new_id     (new_id),
            .new_meta   (new_meta),
            .stays      (cell_stay[i]),
            .id         (cell_id[i]),
            .meta       (cell_meta[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        rsp_data_next                 = '0;
        rsp_data_next.status          = ST_OK;
        rsp_data_next.occupancy       = OCC_W'(count_next);
        if (req.data.action == ACT_INSERT)
        begin
            if (is_full)
            begin
                rsp_data_next.status = ST_FULL;
            end
        end
        else if (req.data.action == ACT_POP)
        begin
            if (is_empty)
            begin
                rsp_data_next.status = ST_EMPTY;
            end
            else
            begin
                rsp_data_next.popped_id       = PID_W'(cell_id[0]);
                rsp_data_next.popped_priority = cell_meta[0].prio;
                rsp_data_next.popped_tag      = cell_meta[0].tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (req_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule
